>>> rtl/core/pdmv_pkg.sv
`default_nettype none

package pdmv_pkg;

	localparam int ROW_W      = 20;
	localparam int WORD_W     = 32;
	localparam int Q_FRAC     = 16;
	localparam int PROD_W     = 2 * WORD_W;
	localparam int SUM_W      = PROD_W + 2;
	localparam int COEF_N     = 5;
	localparam int X_DEPTH    = 4;
	localparam int PEND_DEPTH = 2 * COEF_N;
	localparam int NUM_LANES  = 3;

	localparam int LANE_A = 0;
	localparam int LANE_B = 1;
	localparam int LANE_C = 2;

	localparam logic [ROW_W-1:0] ROW_COUNT_RESET = 20'd4;
	localparam logic [ROW_W-1:0] ROW_MIN         = 20'd4;
	localparam logic [ROW_W-1:0] FIRST_EMIT      = 20'd3;
	localparam logic [ROW_W-1:0] SECOND_EMIT     = 20'd4;

	typedef logic signed [WORD_W-1:0] word_t;

	localparam word_t Y_MAX = 32'sh7FFF_FFFF;
	localparam word_t Y_MIN = 32'sh8000_0000;

	localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(32'd1 << (Q_FRAC - 1));

	typedef struct packed {
		word_t coef_1;
		word_t coef_2;
		word_t coef_3;
		word_t coef_4;
		word_t coef_5;
		word_t x_value;
	} in_item_t;

	typedef struct packed {
		logic [ROW_W-1:0] row_index;
		word_t            y_value;
		logic             last_row;
		logic             overflow;
	} out_item_t;

	typedef struct packed {
		word_t [COEF_N-1:0] coef;
		word_t [COEF_N-1:0] x;
	} lane_ops_t;

	typedef struct packed {
		word_t y;
		logic  ovf;
	} lane_res_t;

	typedef struct packed {
		logic [ROW_W-1:0] row_k;
		logic             ends_product;
	} stage_ctl_t;

	typedef struct packed {
		logic       emit;
		stage_ctl_t ctl;
	} front_t;

endpackage

`default_nettype wire

>>> rtl/core/pentadiagonal_matrix_vector_product.sv
// A result passes the lane product, pair-sum and sum registers and then the output register.
// Throughput: one item per cycle unless the output stage stalls; three product lanes run
// side by side, and an item that ends a product yields three results, sent one at a time.
// Reset: asynchronous, active low; clears the row counter, the x window, the pipeline
// valids and sets row_count to 4. The coefficient store is not cleared.
`default_nettype none

module pentadiagonal_matrix_vector_product (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [pdmv_pkg::ROW_W-1:0] cfg_wdata,
	input  logic                       item_valid,
	output logic                       item_ready,
	input  pdmv_pkg::in_item_t         item,
	output logic                       result_valid,
	input  logic                       result_ready,
	output pdmv_pkg::out_item_t        result
);

	logic ready_s1;
	logic ready_s2;
	logic ready_s3;
	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic take;
	logic accept;

	pdmv_pkg::stage_ctl_t ctl_s1;
	pdmv_pkg::stage_ctl_t ctl_s2;
	pdmv_pkg::stage_ctl_t ctl_s3;
	pdmv_pkg::front_t     front;

	pdmv_pkg::lane_ops_t [pdmv_pkg::NUM_LANES-1:0] ops;
	pdmv_pkg::lane_res_t [pdmv_pkg::NUM_LANES-1:0] res;

	assign ready_s3   = !valid_s3 || take;
	assign ready_s2   = !valid_s2 || ready_s3;
	assign ready_s1   = !valid_s1 || ready_s2;
	assign item_ready = ready_s1;
	assign accept     = item_valid && ready_s1;

	pdmv_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.item      (item),
		.ops       (ops),
		.front     (front)
	);

	for (genvar g = 0; g < pdmv_pkg::NUM_LANES; g++) begin : g_lane
		pdmv_lane u_lane (
			.clk   (clk),
			.en_s1 (ready_s1),
			.en_s2 (ready_s2),
			.en_s3 (ready_s3),
			.ops   (ops[g]),
			.res   (res[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= item_valid && front.emit;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			ctl_s1 <= front.ctl;
		end
		if (ready_s2) begin
			ctl_s2 <= ctl_s1;
		end
		if (ready_s3) begin
			ctl_s3 <= ctl_s2;
		end
	end

	pdmv_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.bundle_valid (valid_s3),
		.ctl          (ctl_s3),
		.res          (res),
		.take         (take),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire

>>> rtl/core/pdmv_window.sv
`default_nettype none

module pdmv_window (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  logic                                                cfg_we,
	input  logic [pdmv_pkg::ROW_W-1:0]                          cfg_wdata,
	input  logic                                                accept,
	input  pdmv_pkg::in_item_t                                  item,
	output pdmv_pkg::lane_ops_t [pdmv_pkg::NUM_LANES-1:0]       ops,
	output pdmv_pkg::front_t                                    front
);

	logic [pdmv_pkg::ROW_W-1:0] row_count_q;
	logic [pdmv_pkg::ROW_W-1:0] row_counter_q;
	logic [pdmv_pkg::ROW_W-1:0] n_eff;
	logic [pdmv_pkg::ROW_W-1:0] row_k;
	logic                       ends;
	logic                       emit;
	logic                       is_r1;
	logic                       is_r2;

	pdmv_pkg::word_t xw_q   [pdmv_pkg::X_DEPTH];
	pdmv_pkg::word_t pend_q [pdmv_pkg::PEND_DEPTH];
	pdmv_pkg::word_t coef   [pdmv_pkg::COEF_N];
	pdmv_pkg::word_t cur    [pdmv_pkg::COEF_N];

	always_comb begin
		n_eff = (row_count_q < pdmv_pkg::ROW_MIN) ? pdmv_pkg::ROW_MIN : row_count_q;
		row_k = row_counter_q + pdmv_pkg::ROW_W'(1);
		ends  = row_k >= n_eff;
		emit  = row_k >= pdmv_pkg::FIRST_EMIT;
		is_r1 = row_k == pdmv_pkg::FIRST_EMIT;
		is_r2 = row_k == pdmv_pkg::SECOND_EMIT;
	end

	always_comb begin
		coef[0] = item.coef_1;
		coef[1] = item.coef_2;
		coef[2] = item.coef_3;
		coef[3] = item.coef_4;
		coef[4] = item.coef_5;
		for (int i = 0; i < pdmv_pkg::X_DEPTH; i++) begin
			cur[i] = xw_q[i];
		end
		cur[pdmv_pkg::X_DEPTH] = item.x_value;
	end

	// lane A: row k-2, lane B: row k-1, lane C: row k
	always_comb begin
		ops = '0;
		for (int i = 0; i < pdmv_pkg::COEF_N; i++) begin
			ops[pdmv_pkg::LANE_A].coef[i] = pend_q[i];
		end
		if (is_r1) begin
			for (int i = 0; i < 3; i++) begin
				ops[pdmv_pkg::LANE_A].x[i] = cur[i + 2];
			end
		end else if (is_r2) begin
			for (int i = 0; i < 4; i++) begin
				ops[pdmv_pkg::LANE_A].x[i] = cur[i + 1];
			end
		end else begin
			for (int i = 0; i < pdmv_pkg::COEF_N; i++) begin
				ops[pdmv_pkg::LANE_A].x[i] = cur[i];
			end
		end
		for (int i = 0; i < 4; i++) begin
			ops[pdmv_pkg::LANE_B].coef[i] = pend_q[pdmv_pkg::COEF_N + i];
			ops[pdmv_pkg::LANE_B].x[i]    = cur[i + 1];
		end
		for (int i = 0; i < 3; i++) begin
			ops[pdmv_pkg::LANE_C].coef[i] = coef[i];
			ops[pdmv_pkg::LANE_C].x[i]    = cur[i + 2];
		end
	end

	always_comb begin
		front.emit             = emit;
		front.ctl.row_k        = row_k;
		front.ctl.ends_product = ends;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q   <= pdmv_pkg::ROW_COUNT_RESET;
			row_counter_q <= '0;
			for (int i = 0; i < pdmv_pkg::X_DEPTH; i++) begin
				xw_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				row_count_q <= cfg_wdata;
			end
			if (accept) begin
				row_counter_q <= ends ? '0 : row_k;
				for (int i = 0; i < pdmv_pkg::X_DEPTH; i++) begin
					xw_q[i] <= ends ? '0 : cur[i + 1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < pdmv_pkg::COEF_N; i++) begin
				pend_q[i]                   <= pend_q[pdmv_pkg::COEF_N + i];
				pend_q[pdmv_pkg::COEF_N + i] <= coef[i];
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/pdmv_lane.sv
`default_nettype none

module pdmv_lane (
	input  logic                clk,
	input  logic                en_s1,
	input  logic                en_s2,
	input  logic                en_s3,
	input  pdmv_pkg::lane_ops_t ops,
	output pdmv_pkg::lane_res_t res
);

	logic signed [pdmv_pkg::PROD_W-1:0] prod_s1 [pdmv_pkg::COEF_N];
	logic signed [pdmv_pkg::SUM_W-1:0]  pair_s2 [2];
	logic signed [pdmv_pkg::SUM_W-1:0]  tail_s2;
	logic signed [pdmv_pkg::SUM_W-1:0]  sum_s3;
	logic [pdmv_pkg::SUM_W-pdmv_pkg::Q_FRAC-pdmv_pkg::WORD_W:0] hi;
	logic fits;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int i = 0; i < pdmv_pkg::COEF_N; i++) begin
				prod_s1[i] <= pdmv_pkg::PROD_W'($signed(ops.coef[i]))
					* pdmv_pkg::PROD_W'($signed(ops.x[i]));
			end
		end
		if (en_s2) begin
			pair_s2[0] <= pdmv_pkg::SUM_W'(prod_s1[0]) + pdmv_pkg::SUM_W'(prod_s1[1]);
			pair_s2[1] <= pdmv_pkg::SUM_W'(prod_s1[2]) + pdmv_pkg::SUM_W'(prod_s1[3]);
			tail_s2    <= pdmv_pkg::SUM_W'(prod_s1[4]) + pdmv_pkg::ROUND_HALF;
		end
		if (en_s3) begin
			sum_s3 <= pair_s2[0] + pair_s2[1] + tail_s2;
		end
	end

	// round half up by the bias added above, then saturate to Q16.16
	always_comb begin
		hi      = sum_s3[pdmv_pkg::SUM_W-1:pdmv_pkg::Q_FRAC+pdmv_pkg::WORD_W-1];
		fits    = (hi == '0) || (hi == '1);
		res.ovf = !fits;
		if (fits) begin
			res.y = sum_s3[pdmv_pkg::Q_FRAC+pdmv_pkg::WORD_W-1:pdmv_pkg::Q_FRAC];
		end else if (sum_s3[pdmv_pkg::SUM_W-1]) begin
			res.y = pdmv_pkg::Y_MIN;
		end else begin
			res.y = pdmv_pkg::Y_MAX;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/pdmv_merge.sv
`default_nettype none

module pdmv_merge (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          bundle_valid,
	input  pdmv_pkg::stage_ctl_t                          ctl,
	input  pdmv_pkg::lane_res_t [pdmv_pkg::NUM_LANES-1:0] res,
	output logic                                          take,
	output logic                                          result_valid,
	input  logic                                          result_ready,
	output pdmv_pkg::out_item_t                           result
);

	logic [pdmv_pkg::NUM_LANES-1:0]                mask_q;
	logic [pdmv_pkg::NUM_LANES-1:0]                mask_rest;
	logic [pdmv_pkg::ROW_W-1:0]                    row_k_q;
	pdmv_pkg::lane_res_t [pdmv_pkg::NUM_LANES-1:0] res_q;

	assign mask_rest    = mask_q & (mask_q - pdmv_pkg::NUM_LANES'(1));
	assign take         = (mask_q == '0) || (result_ready && (mask_rest == '0));
	assign result_valid = |mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (take) begin
			mask_q <= bundle_valid ? {ctl.ends_product, ctl.ends_product, 1'b1} : '0;
		end else if (result_ready) begin
			mask_q <= mask_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			row_k_q <= ctl.row_k;
			res_q   <= res;
		end
	end

	// drain lanes in row order
	always_comb begin
		if (mask_q[pdmv_pkg::LANE_A]) begin
			result.row_index = row_k_q
				- pdmv_pkg::ROW_W'(pdmv_pkg::LANE_C - pdmv_pkg::LANE_A);
			result.y_value   = res_q[pdmv_pkg::LANE_A].y;
			result.overflow  = res_q[pdmv_pkg::LANE_A].ovf;
			result.last_row  = 1'b0;
		end else if (mask_q[pdmv_pkg::LANE_B]) begin
			result.row_index = row_k_q
				- pdmv_pkg::ROW_W'(pdmv_pkg::LANE_C - pdmv_pkg::LANE_B);
			result.y_value   = res_q[pdmv_pkg::LANE_B].y;
			result.overflow  = res_q[pdmv_pkg::LANE_B].ovf;
			result.last_row  = 1'b0;
		end else begin
			result.row_index = row_k_q;
			result.y_value   = res_q[pdmv_pkg::LANE_C].y;
			result.overflow  = res_q[pdmv_pkg::LANE_C].ovf;
			result.last_row  = 1'b1;
		end
	end

endmodule

`default_nettype wire
